### design/pps_pkg.sv
// Shared types and constants for the power path sequencer.
// Used by pps_step and power_path_sequencer_top; depends on nothing else.

package pps_pkg;

  // Power states, as reported in the power_state result field.
  typedef enum logic [1:0] {
    PS_OFF       = 2'd0,
    PS_PRECHARGE = 2'd1,
    PS_ON        = 2'd2,
    PS_FAULT     = 2'd3
  } power_state_e;

  // Fault reasons, as reported in the trip_code result field.
  typedef enum logic [1:0] {
    FC_NONE    = 2'd0,
    FC_TIMEOUT = 2'd1,
    FC_LOST    = 2'd2,
    FC_EDGE    = 2'd3
  } trip_code_e;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 8;
  localparam logic [CfgIdxW-1:0] CFG_PRECHARGE_LIMIT = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_SHUTDOWN_HOLD   = 8'd1;

  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgDataW-1:0] PRECHARGE_LIMIT_RESET = 16'd100;
  localparam logic [CfgDataW-1:0] SHUTDOWN_HOLD_RESET   = 16'd5000;

  // Millisecond phase bookkeeping. The phase runs modulo 1600 ms and is kept
  // as three small counters instead of one value that would need dividing.
  localparam int unsigned PhaseMod        = 1600;
  localparam int unsigned PrechargeBlink  = 20;
  localparam int unsigned LockTickMs      = 100;
  localparam int unsigned HundredsCount   = PhaseMod / LockTickMs;
  localparam int unsigned Sub20W          = $clog2(PrechargeBlink);
  localparam int unsigned Sub100W         = $clog2(LockTickMs);
  localparam int unsigned HundW           = $clog2(HundredsCount);

  localparam logic [Sub20W-1:0]  SUB20_LAST  = Sub20W'(PrechargeBlink - 1);
  localparam logic [Sub100W-1:0] SUB100_LAST = Sub100W'(LockTickMs - 1);
  localparam logic [HundW-1:0]   HUND_LAST   = HundW'(HundredsCount - 1);

  localparam int unsigned LockW  = 15;
  localparam int unsigned TimerW = 16;

  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 24;

  // One input item.
  typedef struct packed {
    logic             ms_tick;
    logic             switch_on;
    logic             hotswap_pin;
    logic             lock_load;
    logic [LockW-1:0] lock_value;
  } pps_in_t;

  // One result item.
  typedef struct packed {
    power_state_e     power_state;
    trip_code_e       trip_code;
    logic             main_drive;
    logic             aux_drive;
    logic             switch_led;
    logic             status_led;
    logic [LockW-1:0] lock_remaining;
  } pps_out_t;

  // Configuration as seen by the step logic.
  typedef struct packed {
    logic [TimerW-1:0] precharge_limit_ms;
    logic [TimerW-1:0] shutdown_hold_ms;
  } pps_cfg_t;

  // Sequencer state carried from one item to the next.
  typedef struct packed {
    power_state_e       power_state;
    trip_code_e         trip_code;
    logic [TimerW-1:0]  precharge_left;
    logic [TimerW-1:0]  shutdown_left;
    logic [LockW-1:0]   lock_left;
    logic [Sub20W-1:0]  sub20;
    logic               blink20;
    logic [Sub100W-1:0] sub100;
    logic [HundW-1:0]   hund;
    logic               flag_prev;
  } pps_state_t;

  localparam pps_state_t STATE_RESET = '{
    power_state:    PS_OFF,
    trip_code:      FC_NONE,
    precharge_left: '0,
    shutdown_left:  '0,
    lock_left:      '0,
    sub20:          '0,
    blink20:        1'b0,
    sub100:         '0,
    hund:           '0,
    flag_prev:      1'b0
  };

endpackage

### design/pps_step.sv
// Next-state and result logic for one pass of the power sequencing loop.
// Purely combinational; depends on pps_pkg.

module pps_step (
  input  pps_pkg::pps_state_t cur_i,
  input  pps_pkg::pps_in_t    item_i,
  input  pps_pkg::pps_cfg_t   cfg_i,
  output pps_pkg::pps_state_t nxt_o,
  output pps_pkg::pps_out_t   res_o
);

  pps_pkg::power_state_e          ps;
  pps_pkg::trip_code_e            fc;
  logic [pps_pkg::LockW-1:0]      lock;
  logic                           flag_edge;
  logic [2:0]                     fault_cycle;
  logic                           fault_lit;
  logic                           o_pwr, o_3v3, o_sled, o_dled;
  pps_pkg::pps_state_t            nxt;

  always_comb begin
    nxt  = cur_i;
    lock = item_i.lock_load ? item_i.lock_value : cur_i.lock_left;

    // A falling flag edge while powering forces the fault state before
    // anything is driven.
    flag_edge = cur_i.flag_prev && !item_i.hotswap_pin &&
                ((cur_i.power_state == pps_pkg::PS_PRECHARGE) ||
                 (cur_i.power_state == pps_pkg::PS_ON));
    ps = flag_edge ? pps_pkg::PS_FAULT : cur_i.power_state;
    fc = flag_edge ? pps_pkg::FC_EDGE : cur_i.trip_code;
    nxt.flag_prev = item_i.hotswap_pin;

    // Fault blink: the 200 ms slot number is the hundreds count halved.
    fault_cycle = cur_i.hund[pps_pkg::HundW-1:1];
    fault_lit   = fault_cycle[0] && (fault_cycle < {fc, 1'b0});

    // Drives follow the state held before the transition.
    o_pwr  = 1'b0;
    o_3v3  = 1'b1;
    o_sled = 1'b0;
    o_dled = 1'b0;
    case (ps)
      pps_pkg::PS_OFF: begin
        o_3v3  = (cur_i.shutdown_left != '0);
        o_dled = 1'b1;
      end
      pps_pkg::PS_PRECHARGE: begin
        o_pwr  = 1'b1;
        o_sled = cur_i.blink20;
      end
      pps_pkg::PS_ON: begin
        o_pwr  = 1'b1;
        o_sled = 1'b1;
      end
      default: begin
        o_sled = fault_lit;
        o_dled = !fault_lit;
      end
    endcase

    // State transition.
    nxt.power_state = ps;
    nxt.trip_code   = fc;
    case (ps)
      pps_pkg::PS_OFF: begin
        nxt.trip_code = pps_pkg::FC_NONE;
        if (item_i.switch_on) begin
          nxt.precharge_left = cfg_i.precharge_limit_ms;
          nxt.power_state    = pps_pkg::PS_PRECHARGE;
        end
      end
      pps_pkg::PS_PRECHARGE: begin
        nxt.trip_code = pps_pkg::FC_NONE;
        if (item_i.hotswap_pin) begin
          nxt.power_state = pps_pkg::PS_ON;
        end else if (!item_i.switch_on) begin
          nxt.power_state = pps_pkg::PS_OFF;
        end else if (cur_i.precharge_left == '0) begin
          nxt.trip_code   = pps_pkg::FC_TIMEOUT;
          nxt.power_state = pps_pkg::PS_FAULT;
        end
        nxt.shutdown_left = cfg_i.shutdown_hold_ms;
      end
      pps_pkg::PS_ON: begin
        nxt.trip_code = pps_pkg::FC_NONE;
        if (!item_i.hotswap_pin) begin
          nxt.power_state = pps_pkg::PS_FAULT;
          nxt.trip_code   = pps_pkg::FC_LOST;
        end else if (!item_i.switch_on && (lock == '0)) begin
          nxt.power_state = pps_pkg::PS_OFF;
        end
        nxt.shutdown_left = cfg_i.shutdown_hold_ms;
      end
      default: begin
        if (!item_i.switch_on) begin
          nxt.power_state = pps_pkg::PS_OFF;
        end
        nxt.shutdown_left = cfg_i.shutdown_hold_ms;
      end
    endcase

    // Millisecond tick: advance the phase counters and run the countdowns.
    nxt.lock_left = lock;
    if (item_i.ms_tick) begin
      if (nxt.shutdown_left != '0) begin
        nxt.shutdown_left = nxt.shutdown_left - 1'b1;
      end
      if (nxt.precharge_left != '0) begin
        nxt.precharge_left = nxt.precharge_left - 1'b1;
      end
      if (cur_i.sub20 == pps_pkg::SUB20_LAST) begin
        nxt.sub20   = '0;
        nxt.blink20 = !cur_i.blink20;
      end else begin
        nxt.sub20 = cur_i.sub20 + 1'b1;
      end
      if (cur_i.sub100 == pps_pkg::SUB100_LAST) begin
        nxt.sub100 = '0;
        nxt.hund   = (cur_i.hund == pps_pkg::HUND_LAST) ? '0 : cur_i.hund + 1'b1;
        if (lock != '0) begin
          nxt.lock_left = lock - 1'b1;
        end
      end else begin
        nxt.sub100 = cur_i.sub100 + 1'b1;
      end
    end
  end

  assign nxt_o = nxt;

  assign res_o = '{
    power_state:    nxt.power_state,
    trip_code:      nxt.trip_code,
    main_drive:     o_pwr,
    aux_drive:      o_3v3,
    switch_led:     o_sled,
    status_led:     o_dled,
    lock_remaining: nxt.lock_left
  };

endmodule

### design/power_path_sequencer_top.sv
// Top level of the power path sequencer: stream ports, input and result
// registers, state and configuration registers. Depends on pps_pkg, pps_step.
//
// Latency: a result passes through the input register and then the result register before it is presented.
// Throughput: one item per cycle; the input register and the result register
// each advance whenever the stage ahead of them is free.
// Reset: rst_ni clears the sequencer to off with all countdowns at zero and
// loads the configuration defaults (precharge 100 ms, shutdown hold 5000 ms).

module power_path_sequencer_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input items. tdata fields from bit 0 up: ms_tick, switch_on, hotswap_pin,
  // lock_load, lock_value[14:0], zero padding.
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [pps_pkg::InDataW-1:0]   s_axis_tdata_i,
  // Result items. tdata fields from bit 0 up: power_state[1:0],
  // trip_code[1:0], main_drive, aux_drive, switch_led, status_led,
  // lock_remaining[14:0], zero padding.
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [pps_pkg::OutDataW-1:0]  m_axis_tdata_o,
  // Configuration writes. Index 0 is the precharge limit, index 1 the
  // shutdown hold time; other indexes are ignored.
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pps_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [pps_pkg::CfgDataW-1:0]  cfg_data_i
);

  // Input register stage.
  logic                      in_valid_q;
  logic [pps_pkg::InDataW-1:0] in_data_q;

  // Result register stage.
  logic                      out_valid_q;
  pps_pkg::pps_out_t         out_q;

  // Sequencer state and configuration.
  pps_pkg::pps_state_t       state_q, state_d;
  pps_pkg::pps_cfg_t         cfg_q;
  pps_pkg::pps_in_t          item;
  pps_pkg::pps_out_t         res;

  logic out_free;
  logic step_fire;

  // The result stage takes a new item whenever it is empty or being drained;
  // the input stage refills whenever its item moves on.
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign step_fire       = in_valid_q && out_free;
  assign s_axis_tready_o = !in_valid_q || out_free;
  assign cfg_ready_o     = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_data_q <= s_axis_tdata_i;
    end
  end

  // Unpack the registered item.
  assign item = '{
    ms_tick:     in_data_q[0],
    switch_on:   in_data_q[1],
    hotswap_pin: in_data_q[2],
    lock_load:   in_data_q[3],
    lock_value:  in_data_q[4 +: pps_pkg::LockW]
  };

  pps_step u_step (
    .cur_i  (state_q),
    .item_i (item),
    .cfg_i  (cfg_q),
    .nxt_o  (state_d),
    .res_o  (res)
  );

  // State advances exactly once per item, as the item enters the result stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pps_pkg::STATE_RESET;
    end else if (step_fire) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.precharge_limit_ms <= pps_pkg::PRECHARGE_LIMIT_RESET;
      cfg_q.shutdown_hold_ms   <= pps_pkg::SHUTDOWN_HOLD_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        pps_pkg::CFG_PRECHARGE_LIMIT: cfg_q.precharge_limit_ms <= cfg_data_i;
        pps_pkg::CFG_SHUTDOWN_HOLD:   cfg_q.shutdown_hold_ms   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_fire) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_q.lock_remaining, out_q.status_led, out_q.switch_led,
                            out_q.aux_drive, out_q.main_drive, out_q.trip_code,
                            out_q.power_state};

  // The sequencer state only moves when an item passes through the step.
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_fire |=> $stable(state_q))
    else $error("sequencer state changed without an item");

  // Precharging and on never carry a fault code.
  a_no_code_powered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.power_state == pps_pkg::PS_PRECHARGE || state_q.power_state == pps_pkg::PS_ON)
    |-> state_q.trip_code == pps_pkg::FC_NONE)
    else $error("fault code set while powered");

  // The fault state always holds the reason it was entered.
  a_fault_has_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.power_state == pps_pkg::PS_FAULT |-> state_q.trip_code != pps_pkg::FC_NONE)
    else $error("fault state without a fault code");

  // Millisecond sub-counters stay within their periods.
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.sub20 <= pps_pkg::SUB20_LAST && state_q.sub100 <= pps_pkg::SUB100_LAST)
    else $error("millisecond phase counter out of range");

  // An item in the result stage that is not taken blocks the step.
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready_i) |-> !step_fire)
    else $error("step fired into a full result stage");

endmodule
